FILE: src/lbi_pkg.sv
// ----------------------------------------------------------------------------
// Line/box intersection package
// Shared types, constants and the Q16.16 saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lbi_pkg;

    localparam int DATA_W     = 32;
    localparam int NUM_AXES   = 3;
    localparam int NUM_FACES  = 6;
    localparam int IN_W       = 2 * NUM_AXES * DATA_W;
    localparam int OUT_W      = 8 * DATA_W;

    // Divider: quotient bits resolved per pipeline stage.
    localparam int DIV_BITS   = 32;
    localparam int DIV_RADIX  = 2;
    localparam int DIV_STAGES = DIV_BITS / DIV_RADIX;

    // Face unit latency: operand prep, divider stages, sign and saturate.
    localparam int FACE_LAT   = DIV_STAGES + 2;

    // Valid line: input stage, face units, product, coordinate, face test.
    localparam int PIPE_DEPTH = 1 + FACE_LAT + 3;

    localparam int CFG_IDX_W  = 3;
    localparam int TOL_W      = 31;

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd6;

    typedef logic signed [DATA_W-1:0] q_t;

    localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam q_t Q_ONE = 32'sd65536;

    // Box configuration as seen by the pipeline stages.
    typedef struct packed {
        logic [NUM_AXES-1:0][DATA_W-1:0] lo;
        logic [NUM_AXES-1:0][DATA_W-1:0] hi;
        logic [TOL_W-1:0]                tol;
    } box_t;

    function automatic q_t sat32(input logic signed [48:0] v);
        q_t res;
        if (v > 49'sd2147483647) begin
            res = Q_MAX;
        end else if (v < -49'sd2147483648) begin
            res = Q_MIN;
        end else begin
            res = q_t'(v[DATA_W-1:0]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/line_box_intersect.sv
// ----------------------------------------------------------------------------
// Line / axis-aligned box intersection
// Each request is a line S + t*D in signed Q16.16. The block solves the line
// parameter on the six box faces in the order x-low, x-high, y-low, y-high,
// z-low, z-high, keeps crossings whose free coordinates lie inside the box
// (inclusive) and returns a hit flag, the first crossing and the first later
// crossing whose parameter differs from it by more than the tolerance. A lone
// crossing is repeated as the second; with no crossing every field is zero.
// Faces whose direction component is zero are skipped. The block accepts one
// request per clock and returns one result per request in order; the six
// parallel face dividers resolve two quotient bits per stage over sixteen
// stages. A stall on the output freezes the whole pipeline, so nothing is
// dropped or repeated. The box is written over the configuration channel,
// which is always ready; write it only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module line_box_intersect (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // s_tdata: start_x, start_y, start_z, dir_x, dir_y, dir_z (32 bits each)
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,
    // m_tdata: t_first, first_x, first_y, first_z,
    //          t_second, second_x, second_y, second_z (32 bits each)
    // m_tuser: hit
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [255:0]      m_tdata,
    output logic              m_tuser,
    // Configuration: register index and write data.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam int FL = lbi_pkg::FACE_LAT;
    localparam int PD = lbi_pkg::PIPE_DEPTH;

    lbi_pkg::box_t box_reg;

    logic                             adv;
    logic [PD-1:0]                    vld_reg;
    logic [lbi_pkg::IN_W-1:0]         in_reg;
    logic [FL-1:0][lbi_pkg::IN_W-1:0] sd_reg;
    logic [lbi_pkg::IN_W-1:0]         sd_out;

    logic [5:0][31:0]      bound_f;
    logic [5:0][31:0]      t_face;

    logic signed [63:0]    prod_reg [6][3];
    logic [5:0][31:0]      t_m_reg;
    logic [95:0]           s_m_reg;
    logic [2:0]            nz_m_reg;

    logic [5:0][2:0][31:0] pt_c_reg;
    logic [5:0][31:0]      t_c_reg;
    logic [5:0]            ok_c_reg;

    logic                  sel_hit;
    logic [255:0]          sel_data;

    logic                  m_tvalid_reg;
    logic [255:0]          m_tdata_reg;
    logic                  m_tuser_reg;

    // The whole pipeline moves when the output register is free or drained.
    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg.lo  <= '0;
            box_reg.hi  <= {3{lbi_pkg::Q_ONE}};
            box_reg.tol <= 31'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                lbi_pkg::REG_X_LOW:  box_reg.lo[0] <= cfg_data;
                lbi_pkg::REG_X_HIGH: box_reg.hi[0] <= cfg_data;
                lbi_pkg::REG_Y_LOW:  box_reg.lo[1] <= cfg_data;
                lbi_pkg::REG_Y_HIGH: box_reg.hi[1] <= cfg_data;
                lbi_pkg::REG_Z_LOW:  box_reg.lo[2] <= cfg_data;
                lbi_pkg::REG_Z_HIGH: box_reg.hi[2] <= cfg_data;
                lbi_pkg::REG_TOL:    box_reg.tol <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel alongside the data through every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[PD-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[PD-1];
        end
    end

    // Input register, and a delay line that keeps S and D aligned with the
    // face parameters coming out of the dividers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg <= s_tdata;
            sd_reg <= {sd_reg[FL-2:0], in_reg};
        end
    end

    assign sd_out = sd_reg[FL-1];

    // Even faces sit on the low bound of their axis, odd faces on the high.
    always_comb begin
        for (int f = 0; f < 6; f++) begin
            bound_f[f] = f[0] ? box_reg.hi[f/2] : box_reg.lo[f/2];
        end
    end

    for (genvar f = 0; f < 6; f++) begin : g_face
        lbi_face u_face (
            .aclk  (aclk),
            .en    (adv),
            .s_a   (in_reg[(f/2)*32 +: 32]),
            .d_a   (in_reg[96 + (f/2)*32 +: 32]),
            .bound (bound_f[f]),
            .t     (t_face[f])
        );
    end

    // Product stage: t times the direction on each free axis.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int f = 0; f < 6; f++) begin
                for (int b = 0; b < 3; b++) begin
                    if (b != f / 2) begin
                        prod_reg[f][b] <= $signed(t_face[f]) *
                                          $signed(sd_out[96 + b*32 +: 32]);
                    end else begin
                        prod_reg[f][b] <= '0;
                    end
                end
            end
            t_m_reg <= t_face;
            s_m_reg <= sd_out[95:0];
            for (int a = 0; a < 3; a++) begin
                nz_m_reg[a] <= (sd_out[96 + a*32 +: 32] != 32'd0);
            end
        end
    end

    // Coordinate stage: S plus the floored Q16.16 product, saturated. The
    // coordinate on the face's own axis is the bound itself.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int f = 0; f < 6; f++) begin
                for (int b = 0; b < 3; b++) begin
                    if (b == f / 2) begin
                        pt_c_reg[f][b] <= bound_f[f];
                    end else begin
                        pt_c_reg[f][b] <= lbi_pkg::sat32(
                            {{17{s_m_reg[b*32 + 31]}}, s_m_reg[b*32 +: 32]} +
                            {prod_reg[f][b][63], prod_reg[f][b][63:16]});
                    end
                end
                ok_c_reg[f] <= nz_m_reg[f/2];
            end
            t_c_reg <= t_m_reg;
        end
    end

    lbi_sel u_sel (
        .aclk    (aclk),
        .en      (adv),
        .box     (box_reg),
        .face_ok (ok_c_reg),
        .t_i     (t_c_reg),
        .pt_i    (pt_c_reg),
        .hit     (sel_hit),
        .data    (sel_data)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= sel_data;
            m_tuser_reg <= sel_hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: src/lbi_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned 32-bit quotient, a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lbi_div (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] rem_i,   // upper dividend bits, below the divisor
    input  wire logic [31:0] low_i,   // lower dividend bits, shifted in
    input  wire logic [31:0] den_i,
    input  wire logic        neg_i,
    input  wire logic        ovf_i,
    output logic      [31:0] q_o,
    output logic             neg_o,
    output logic             ovf_o
);

    localparam int NS = lbi_pkg::DIV_STAGES;

    logic [31:0] rem_reg [NS];
    logic [31:0] wq_reg  [NS];
    logic [31:0] den_reg [NS];
    logic        neg_reg [NS];
    logic        ovf_reg [NS];

    function automatic logic [63:0] div_step(input logic [31:0] r_in,
                                             input logic [31:0] w_in,
                                             input logic [31:0] den);
        logic [31:0] r;
        logic [31:0] w;
        logic [32:0] trial;
        r = r_in;
        w = w_in;
        for (int i = 0; i < lbi_pkg::DIV_RADIX; i++) begin
            trial = {r, w[31]};
            w     = {w[30:0], 1'b0};
            if (trial >= {1'b0, den}) begin
                r    = 32'(trial - {1'b0, den});
                w[0] = 1'b1;
            end else begin
                r = trial[31:0];
            end
        end
        return {r, w};
    endfunction

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [31:0] r_in;
        logic [31:0] w_in;
        logic [31:0] d_in;
        logic        n_in;
        logic        o_in;
        logic [63:0] step;

        if (k == 0) begin : g_first
            assign r_in = rem_i;
            assign w_in = low_i;
            assign d_in = den_i;
            assign n_in = neg_i;
            assign o_in = ovf_i;
        end else begin : g_next
            assign r_in = rem_reg[k-1];
            assign w_in = wq_reg[k-1];
            assign d_in = den_reg[k-1];
            assign n_in = neg_reg[k-1];
            assign o_in = ovf_reg[k-1];
        end

        assign step = div_step(r_in, w_in, d_in);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= step[63:32];
                wq_reg[k]  <= step[31:0];
                den_reg[k] <= d_in;
                neg_reg[k] <= n_in;
                ovf_reg[k] <= o_in;
            end
        end
    end

    assign q_o   = wq_reg[NS-1];
    assign neg_o = neg_reg[NS-1];
    assign ovf_o = ovf_reg[NS-1];

endmodule

`default_nettype wire

FILE: src/lbi_face.sv
// ----------------------------------------------------------------------------
// Face parameter unit
// Solves t = ((bound - s) * 2^16) / d for one face plane, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module lbi_face (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [31:0] s_a,
    input  wire logic signed [31:0] d_a,
    input  wire logic signed [31:0] bound,
    output lbi_pkg::q_t             t
);

    logic signed [32:0] diff;
    logic        [32:0] diff_mag;
    logic        [31:0] den_mag;
    logic        [16:0] num_hi;

    logic [31:0] rem0_reg;
    logic [31:0] low_reg;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic        ovf_reg;

    logic [31:0] q;
    logic        q_neg;
    logic        q_ovf;
    lbi_pkg::q_t t_next;
    lbi_pkg::q_t t_reg;

    // The numerator is |bound - s| shifted up by the fraction width.
    // A quotient of 2^32 or more shows already in its top 17 bits.
    assign diff     = {bound[31], bound} - {s_a[31], s_a};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign den_mag  = d_a[31] ? 32'(-d_a) : 32'(d_a);
    assign num_hi   = diff_mag[32:16];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg <= {15'b0, num_hi};
            low_reg  <= {diff_mag[15:0], 16'b0};
            den_reg  <= den_mag;
            neg_reg  <= diff[32] ^ d_a[31];
            ovf_reg  <= ({15'b0, num_hi} >= den_mag);
        end
    end

    lbi_div u_div (
        .aclk  (aclk),
        .en    (en),
        .rem_i (rem0_reg),
        .low_i (low_reg),
        .den_i (den_reg),
        .neg_i (neg_reg),
        .ovf_i (ovf_reg),
        .q_o   (q),
        .neg_o (q_neg),
        .ovf_o (q_ovf)
    );

    always_comb begin
        if (q_ovf || q[31]) begin
            t_next = q_neg ? lbi_pkg::Q_MIN : lbi_pkg::Q_MAX;
        end else if (q_neg) begin
            t_next = lbi_pkg::q_t'(-{1'b0, q[30:0]});
        end else begin
            t_next = lbi_pkg::q_t'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= t_next;
        end
    end

    assign t = t_reg;

endmodule

`default_nettype wire

FILE: src/lbi_sel.sv
// ----------------------------------------------------------------------------
// Crossing selection
// Tests each face crossing against the box and picks up to two crossings.
// ----------------------------------------------------------------------------
`default_nettype none

module lbi_sel (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire lbi_pkg::box_t         box,
    input  wire logic [5:0]            face_ok,
    input  wire logic [5:0][31:0]      t_i,
    input  wire logic [5:0][2:0][31:0] pt_i,
    output logic                       hit,
    output logic [lbi_pkg::OUT_W-1:0]  data
);

    logic [5:0]            inside_next;
    logic [5:0][5:0]       gap_next;
    logic [5:0]            inside_reg;
    logic [5:0][5:0]       gap_reg;
    logic [5:0][31:0]      t_reg;
    logic [5:0][2:0][31:0] pt_reg;

    logic       found1;
    logic       found2;
    logic [2:0] i1;
    logic [2:0] i2;
    logic [2:0] isec;

    // A crossing counts when both free coordinates are inside the bounds.
    always_comb begin
        logic ok;
        for (int f = 0; f < 6; f++) begin
            ok = face_ok[f];
            for (int b = 0; b < 3; b++) begin
                if (b != f / 2) begin
                    if ($signed(pt_i[f][b]) < $signed(box.lo[b]) ||
                        $signed(pt_i[f][b]) > $signed(box.hi[b])) begin
                        ok = 1'b0;
                    end
                end
            end
            inside_next[f] = ok;
        end
    end

    // Pairwise distance test for every earlier/later face pair.
    always_comb begin
        logic [32:0] diff;
        logic [32:0] mag;
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 6; j++) begin
                diff = {t_i[j][31], t_i[j]} - {t_i[i][31], t_i[i]};
                mag  = diff[32] ? 33'(-diff) : diff;
                gap_next[i][j] = (i < j) && (mag > {2'b0, box.tol});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inside_reg <= inside_next;
            gap_reg    <= gap_next;
            t_reg      <= t_i;
            pt_reg     <= pt_i;
        end
    end

    always_comb begin
        found1 = 1'b0;
        found2 = 1'b0;
        i1     = 3'd0;
        i2     = 3'd0;
        for (int j = 0; j < 6; j++) begin
            if (inside_reg[j]) begin
                if (!found1) begin
                    found1 = 1'b1;
                    i1     = 3'(j);
                end else if (!found2 && gap_reg[i1][j]) begin
                    found2 = 1'b1;
                    i2     = 3'(j);
                end
            end
        end
    end

    assign isec = found2 ? i2 : i1;
    assign hit  = found1;

    always_comb begin
        if (found1) begin
            data = {pt_reg[isec][2], pt_reg[isec][1], pt_reg[isec][0], t_reg[isec],
                    pt_reg[i1][2], pt_reg[i1][1], pt_reg[i1][0], t_reg[i1]};
        end else begin
            data = '0;
        end
    end

endmodule

`default_nettype wire

FILE: src/lbi_checker.sv
// ----------------------------------------------------------------------------
// Line/box intersection port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lbi_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [255:0] m_tdata,
    input wire logic         m_tuser
);

    // A result held back by the sink stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A miss carries all-zero fields.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with nonzero fields");

    // The input side takes requests whenever the output register can move.
    a_ready_free: assert property (@(posedge aclk)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_ready_stall: assert property (@(posedge aclk)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind line_box_intersect lbi_checker u_lbi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
